// ===== hdl/i2cms_pkg.sv =====
// Package for the I2C master sensor read step block.
// Holds the request, result and configuration types, codes and slot helpers.
// No dependencies.
package i2cms_pkg;

   localparam int NUM_SLOTS         = 8;
   localparam int BYTES_PER_REG_DEF = 2;
   localparam int SLOT_IDX_W        = $clog2(NUM_SLOTS);
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_DATA_W        = 32;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SEND = 2'd1,
      ACT_STOP = 2'd2
   } bus_action_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_EVENT = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_REG_POINTER     = 2'd0,
      CSR_TRANSFER_LENGTH = 2'd1,
      CSR_WRITE_WORD      = 2'd2
   } csr_index_type;

   localparam logic [SLOT_IDX_W-1:0] SLOT_VOLT  = SLOT_IDX_W'(2);
   localparam logic [SLOT_IDX_W-1:0] SLOT_POWER = SLOT_IDX_W'(3);
   localparam logic [SLOT_IDX_W-1:0] SLOT_ID    = SLOT_IDX_W'(6);
   localparam logic [SLOT_IDX_W-1:0] SLOT_TEMP  = SLOT_IDX_W'(7);
   localparam logic [7:0]            PTR_ID     = 8'd255;
   localparam logic [7:0]            PTR_LAST   = 8'd5;

   typedef struct packed {
      logic [7:0]  reg_pointer;
      logic [1:0]  transfer_length;
      logic [15:0] write_word;
   } cfg_type;

   typedef struct packed {
      req_kind_type req_type;
      logic         arb_lost;
      logic         bus_error;
      logic         rx_nack;
      logic         write_ready;
      logic         read_ready;
      logic [7:0]   rx_byte;
   } req_item_type;

   typedef struct packed {
      bus_action_type         bus_action;
      logic [7:0]             tx_byte;
      logic                   clear_arb_flag;
      logic                   slot_written;
      logic [SLOT_IDX_W-1:0]  slot_index;
      logic [15:0]            slot_value;
   } rsp_item_type;

   function automatic logic [SLOT_IDX_W-1:0] pick_slot(input logic [7:0] ptr);
      logic [SLOT_IDX_W-1:0] s;
      if (ptr <= PTR_LAST) begin
         s = ptr[SLOT_IDX_W-1:0];
      end else if (ptr == PTR_ID) begin
         s = SLOT_ID;
      end else begin
         s = SLOT_TEMP;
      end
      return s;
   endfunction

endpackage

// ===== hdl/i2cms_csr.sv =====
// Configuration registers of the I2C master sensor read step block.
// APB-style write and read access; depends on i2cms_pkg.
module i2cms_csr
   import i2cms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = csr_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_REG_POINTER:     cfg_in.reg_pointer     = pwdata[7:0];
            CSR_TRANSFER_LENGTH: cfg_in.transfer_length = pwdata[1:0];
            CSR_WRITE_WORD:      cfg_in.write_word      = pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_REG_POINTER:     prdata = CSR_DATA_W'(cfg_ff.reg_pointer);
         CSR_TRANSFER_LENGTH: prdata = CSR_DATA_W'(cfg_ff.transfer_length);
         CSR_WRITE_WORD:      prdata = CSR_DATA_W'(cfg_ff.write_word);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reg_pointer     <= 8'd0;
         cfg_ff.transfer_length <= 2'd2;
         cfg_ff.write_word      <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/i2cms_core.sv =====
// Event handling and transfer state of the I2C master sensor read step block.
// Holds the pointer flag, byte counter and sensor slots; depends on i2cms_pkg.
module i2cms_core
   import i2cms_pkg::*;
#(
   parameter int BYTES_PER_REG = BYTES_PER_REG_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   localparam logic [1:0] MAX_LEN    = 2'(BYTES_PER_REG);
   localparam logic [3:0] HIGH_SHIFT = 4'((BYTES_PER_REG - 1) * 8);

   logic        pointer_sent_ff, pointer_sent_in;
   logic [1:0]  byte_count_ff, byte_count_in;
   logic [15:0] slots_ff [NUM_SLOTS];
   logic [15:0] slots_in [NUM_SLOTS];

   logic [1:0]            len;
   logic [SLOT_IDX_W-1:0] sel;
   logic [3:0]            shift_amt;
   logic [15:0]           byte_mask;
   logic [15:0]           raw;
   logic [15:0]           filled;
   logic [15:0]           tx_word;
   logic [18:0]           power_x5;

   assign len       = (cfg.transfer_length > MAX_LEN) ? MAX_LEN : cfg.transfer_length;
   assign sel       = pick_slot(cfg.reg_pointer);
   assign shift_amt = 4'((BYTES_PER_REG - 1 - int'(byte_count_ff)) * 8);
   assign byte_mask = 16'h00ff << shift_amt;
   assign raw       = slots_ff[sel];
   assign filled    = (raw & ~byte_mask) | (16'(item.rx_byte) << shift_amt);
   assign tx_word   = cfg.write_word >> shift_amt;
   assign power_x5  = 19'(raw) * 19'd5;

   always_comb begin
      result          = '0;
      result.bus_action = ACT_NONE;
      pointer_sent_in = pointer_sent_ff;
      byte_count_in   = byte_count_ff;
      slots_in        = slots_ff;
      if (item.req_type == REQ_START) begin
         pointer_sent_in = 1'b0;
         byte_count_in   = 2'd0;
      end else if (item.arb_lost) begin
         result.clear_arb_flag = 1'b1;
         result.bus_action     = ACT_STOP;
      end else if (item.bus_error || item.rx_nack) begin
         result.bus_action   = ACT_STOP;
         slots_in[SLOT_TEMP] = slots_ff[SLOT_TEMP] & ~(16'h00ff << HIGH_SHIFT);
         result.slot_written = 1'b1;
         result.slot_index   = SLOT_TEMP;
         result.slot_value   = slots_in[SLOT_TEMP];
      end else if (item.write_ready) begin
         if (!pointer_sent_ff) begin
            result.bus_action = ACT_SEND;
            result.tx_byte    = cfg.reg_pointer;
            pointer_sent_in   = 1'b1;
         end else if (byte_count_ff < len && len != 2'd0) begin
            result.bus_action = ACT_SEND;
            result.tx_byte    = tx_word[7:0];
            byte_count_in     = byte_count_ff + 2'd1;
         end else begin
            result.bus_action = ACT_STOP;
         end
      end else if (item.read_ready) begin
         if (byte_count_ff < len) begin
            slots_in[sel]       = filled;
            byte_count_in       = byte_count_ff + 2'd1;
            result.slot_written = 1'b1;
            result.slot_index   = sel;
            result.slot_value   = filled;
         end else begin
            result.bus_action = ACT_STOP;
            // Voltage LSB is 1/8 of the raw count; power scales by 5/2.
            if (sel == SLOT_VOLT) begin
               slots_in[sel]       = raw >> 3;
               result.slot_written = 1'b1;
               result.slot_index   = sel;
               result.slot_value   = raw >> 3;
            end else if (sel == SLOT_POWER) begin
               slots_in[sel]       = power_x5[16:1];
               result.slot_written = 1'b1;
               result.slot_index   = sel;
               result.slot_value   = power_x5[16:1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_sent_ff <= 1'b0;
         byte_count_ff   <= 2'd0;
         slots_ff        <= '{default: '0};
      end else if (step) begin
         pointer_sent_ff <= pointer_sent_in;
         byte_count_ff   <= byte_count_in;
         slots_ff        <= slots_in;
      end
   end

endmodule

// ===== hdl/i2c_master_sensor_read_step.sv =====
// Top level of the I2C master sensor read step block.
// Request register, result register, CSR block and event core; depends on i2cms_pkg.
//
// Usage: each request is either a start (req_type 0), which clears the pointer
// flag and byte counter, or a bus event carrying the master status flags and the
// received byte. Every request produces exactly one result on the rsp_ channel:
// the bus action, the byte to send, the arbitration clear flag and the sensor
// slot that changed. A request is taken when req_valid is high and req_stall is
// low; a result is taken when rsp_valid is high and rsp_stall is low.
// A request passes through the request register, then the event logic loads the
// result register. Throughput is one request per cycle while the receiver does not
// stall; the slot and counter update for a request lands in the same cycle its
// result is registered, so the next request sees it at once. When the receiver
// stalls, the result register holds and the request register holds its request,
// and req_stall rises only while both are full. Synchronous reset clears the
// counters, all eight sensor slots and both valid flags, and returns the registers
// to pointer 0, length 2 and write word 0. The user must write registers over the
// APB-style port only while no request is in flight; the block does not enforce it.
module i2c_master_sensor_read_step
   import i2cms_pkg::*;
#(
   parameter int BYTES_PER_REG = BYTES_PER_REG_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic                  req_arb_lost,
   input  logic                  req_bus_error,
   input  logic                  req_rx_nack,
   input  logic                  req_write_ready,
   input  logic                  req_read_ready,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_bus_action,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_clear_arb_flag,
   output logic                  rsp_slot_written,
   output logic [SLOT_IDX_W-1:0] rsp_slot_index,
   output logic [15:0]           rsp_slot_value,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;
   req_item_type req_item_ff, req_item_in;
   logic         req_valid_ff;
   rsp_item_type rsp_item_ff, result;
   logic         rsp_valid_ff;
   logic         rsp_open;
   logic         step;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign step      = req_valid_ff && rsp_open;
   assign req_stall = req_valid_ff && !rsp_open;

   always_comb begin
      req_item_in.req_type    = req_kind_type'(req_type);
      req_item_in.arb_lost    = req_arb_lost;
      req_item_in.bus_error   = req_bus_error;
      req_item_in.rx_nack     = req_rx_nack;
      req_item_in.write_ready = req_write_ready;
      req_item_in.read_ready  = req_read_ready;
      req_item_in.rx_byte     = req_rx_byte;
   end

   i2cms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   i2cms_core #(
      .BYTES_PER_REG (BYTES_PER_REG)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_item_ff <= req_item_in;
      end
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bus_action     = rsp_item_ff.bus_action;
   assign rsp_tx_byte        = rsp_item_ff.tx_byte;
   assign rsp_clear_arb_flag = rsp_item_ff.clear_arb_flag;
   assign rsp_slot_written   = rsp_item_ff.slot_written;
   assign rsp_slot_index     = rsp_item_ff.slot_index;
   assign rsp_slot_value     = rsp_item_ff.slot_value;

endmodule
